### design/jpi_pkg.sv
// ============================================================================
// Joystick port interface package
// Shared types, codes and helpers for the two-channel joystick port block.
// ============================================================================
package jpi_pkg;

	// Width of one key code in a key table, and the signed axis dead zone.
	localparam int KEY_BITS      = 9;
	localparam int AXIS_DEADZONE = 3200;

	// Six key codes are packed in each table: up, down, left, right, fire1, fire2.
	localparam int KEY_SLOTS   = 6;
	localparam int KEY_TABLE_W = KEY_SLOTS * KEY_BITS;
	localparam int CFG_DATA_W  = KEY_TABLE_W;
	localparam int CFG_IDX_W   = 3;

	// Positions of the direction and fire bits in a stick's bit set.
	localparam int BIT_UP    = 0;
	localparam int BIT_DOWN  = 1;
	localparam int BIT_LEFT  = 2;
	localparam int BIT_RIGHT = 3;
	localparam int BIT_FIRE1 = 4;
	localparam int BIT_FIRE2 = 5;

	// Event kinds.
	localparam logic [2:0] EV_KEY_DOWN    = 3'd1;
	localparam logic [2:0] EV_KEY_UP      = 3'd2;
	localparam logic [2:0] EV_AXIS        = 3'd3;
	localparam logic [2:0] EV_BUTTON_DOWN = 3'd4;
	localparam logic [2:0] EV_BUTTON_UP   = 3'd5;

	// Channel modes.
	localparam logic [3:0] CH_KEYS1     = 4'd1;
	localparam logic [3:0] CH_KEYS2     = 4'd2;
	localparam logic [3:0] CH_PAD_FIRST = 4'd4;
	localparam logic [3:0] CH_PAD_LAST  = 4'd13;

	// Axis numbers that move a direction.
	localparam logic [7:0] AXIS_HORIZ = 8'd0;
	localparam logic [7:0] AXIS_VERT  = 8'd1;

	// Interface styles.
	localparam logic [1:0] IF_STYLE_ONE = 2'd1;
	localparam logic [1:0] IF_STYLE_TWO = 2'd2;

	// Mask constants.
	localparam logic [7:0] MASK_IDLE      = 8'hff;
	localparam logic [7:0] MASK_TWO_BASE  = 8'hdf;
	localparam logic [7:0] SEL_STICK_HI   = 8'h80;
	localparam logic [7:0] SEL_STICK_LO   = 8'h40;

	// Per-bit clear masks for the five bits that reach the port.
	localparam logic [7:0] STYLE_ONE_CLR [5] = '{8'hef, 8'hf7, 8'hfe, 8'hfd, 8'hdf};
	localparam logic [7:0] STYLE_TWO_CLR [5] = '{8'hef, 8'hf7, 8'hfd, 8'hfe, 8'hfb};

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTERFACE_KIND = 3'd0,
		CFG_MODE_A         = 3'd1,
		CFG_MODE_B         = 3'd2,
		CFG_KEY_TABLE_ONE  = 3'd3,
		CFG_KEY_TABLE_TWO  = 3'd4,
		CFG_PAD_A_PRESENT  = 3'd5,
		CFG_PAD_B_PRESENT  = 3'd6
	} cfg_idx_t;

	// One host event.
	typedef struct packed {
		logic [2:0]         mode;
		logic [8:0]         key_code;
		logic [7:0]         device_index;
		logic [7:0]         axis_number;
		logic signed [15:0] axis_value;
		logic [7:0]         button_number;
		logic [7:0]         port_a_select;
		logic               ddr_b_bit4;
		logic               port_b_bit4;
		logic [7:0]         sound_port_value;
	} event_t;

	// One result.
	typedef struct packed {
		logic       swallowed;
		logic       port_write;
		logic [7:0] port_write_value;
		logic [7:0] joystick_mask;
	} result_t;

	// What one channel decides about an event.
	typedef struct packed {
		logic       took;
		logic [5:0] bits;
	} chan_res_t;

	// Clear the mask bits that belong to the active stick bits.
	function automatic logic [7:0] apply_bits(input logic [7:0] m, input logic [5:0] bits,
			input logic style_two);
		logic [7:0] r;
		r = m;
		for (int i = 0; i < 5; i++) begin
			if (bits[i]) begin
				r = r & (style_two ? STYLE_TWO_CLR[i] : STYLE_ONE_CLR[i]);
			end
		end
		return r;
	endfunction

endpackage

### design/jpi_ifs.sv
// ============================================================================
// Joystick port interface channels
// Valid/ready channels for events, results and configuration writes.
// ============================================================================
interface jpi_event_if import jpi_pkg::*; ();
	logic   valid;
	logic   ready;
	event_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface jpi_result_if import jpi_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface jpi_cfg_if import jpi_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/jpi_channel.sv
// ============================================================================
// Joystick channel decoder
// Interprets one event for one channel and gives the updated stick bits.
// ============================================================================
module jpi_channel import jpi_pkg::*; (
	input  event_t                 ev,
	input  logic [3:0]             mode,
	input  logic                   present,
	input  logic [KEY_TABLE_W-1:0] tab,
	input  logic [5:0]             bits_q,
	output chan_res_t              res
);

	localparam logic signed [15:0] DZ_POS = 16'(AXIS_DEADZONE);
	localparam logic signed [15:0] DZ_NEG = 16'(-AXIS_DEADZONE);

	logic [KEY_BITS-1:0] key;
	logic                dev_hit;
	logic                is_key_mode;
	logic                is_pad_mode;

	assign key         = KEY_BITS'(ev.key_code);
	assign dev_hit     = (ev.device_index == 8'(mode - CH_PAD_FIRST));
	assign is_key_mode = (mode == CH_KEYS1) || (mode == CH_KEYS2);
	assign is_pad_mode = (mode >= CH_PAD_FIRST) && (mode <= CH_PAD_LAST);

	// Key table match, axis thresholds and button decode.
	always_comb begin
		res.took = 1'b0;
		res.bits = bits_q;
		if (is_key_mode) begin
			if ((ev.mode == EV_KEY_DOWN) || (ev.mode == EV_KEY_UP)) begin
				for (int i = 0; i < KEY_SLOTS; i++) begin
					if (tab[i*KEY_BITS +: KEY_BITS] == key) begin
						res.took    = 1'b1;
						res.bits[i] = (ev.mode == EV_KEY_DOWN);
					end
				end
			end
		end else if (is_pad_mode && present && dev_hit) begin
			case (ev.mode) inside
				EV_AXIS: begin
					res.took = 1'b1;
					case (ev.axis_number)
						AXIS_HORIZ: begin
							res.bits[BIT_LEFT]  = (ev.axis_value < DZ_NEG);
							res.bits[BIT_RIGHT] = (ev.axis_value > DZ_POS);
						end
						AXIS_VERT: begin
							res.bits[BIT_UP]   = (ev.axis_value < DZ_NEG);
							res.bits[BIT_DOWN] = (ev.axis_value > DZ_POS);
						end
						default: ;
					endcase
				end
				EV_BUTTON_DOWN, EV_BUTTON_UP: begin
					res.took = 1'b1;
					if (ev.button_number[0]) begin
						res.bits[BIT_FIRE2] = (ev.mode == EV_BUTTON_DOWN);
					end else begin
						res.bits[BIT_FIRE1] = (ev.mode == EV_BUTTON_DOWN);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### design/joystick_port_interface_core.sv
// ============================================================================
// Joystick port interface core
// Turns host input events into joystick masks driven onto port A.
// ============================================================================
// Usage:
// Events enter on evt_in, one item per accepted valid/ready handshake, and
// every event gives exactly one result item on res_out. Configuration is
// written on cfg (register index plus data) while no event is in flight;
// cfg is always ready.
// Each event is captured in an input register, decoded by both channel
// decoders and the mask logic combinationally, and lands in the result
// register, from which it is offered on res_out. The block sustains one
// item per cycle while the receiver takes results; that rate is set by
// the single stick-bit and port-ownership update done when an item
// leaves the input register.
// If the receiver stalls, the result register holds its item and the input
// register keeps one more item, after which evt_in.ready drops.
// Reset clears the configuration, clears both sticks, sets the mask to all
// ones and hands port A to the sound chip.
// ============================================================================
module joystick_port_interface_core import jpi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	jpi_event_if.sink     evt_in,
	jpi_result_if.source  res_out,
	jpi_cfg_if.sink       cfg
);

	// Configuration registers.
	logic [1:0]             kind_q;
	logic [3:0]             mode_a_q;
	logic [3:0]             mode_b_q;
	logic [KEY_TABLE_W-1:0] table_one_q;
	logic [KEY_TABLE_W-1:0] table_two_q;
	logic                   pad_a_q;
	logic                   pad_b_q;

	// Block state.
	logic [5:0] stick_a_q;
	logic [5:0] stick_b_q;
	logic       owned_q;
	logic [7:0] last_mask_q;

	// Pipeline.
	logic    v_s1;
	event_t  ev_s1;
	logic    out_valid_q;
	result_t res_q;
	logic    advance_s1;

	// Step logic.
	logic [KEY_TABLE_W-1:0] tab_a;
	logic [KEY_TABLE_W-1:0] tab_b;
	chan_res_t              ch_a;
	chan_res_t              ch_b;
	logic                   swallow;
	logic                   grab;
	logic [7:0]             mask;
	result_t                res_d;
	logic                   owned_d;

	assign cfg.ready     = 1'b1;
	assign advance_s1    = v_s1 && (!out_valid_q || res_out.ready);
	assign evt_in.ready  = !v_s1 || advance_s1;
	assign res_out.valid = out_valid_q;
	assign res_out.payload = res_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= '0;
			mode_a_q    <= '0;
			mode_b_q    <= '0;
			table_one_q <= '0;
			table_two_q <= '0;
			pad_a_q     <= 1'b0;
			pad_b_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_INTERFACE_KIND: kind_q      <= cfg.data[1:0];
				CFG_MODE_A:         mode_a_q    <= cfg.data[3:0];
				CFG_MODE_B:         mode_b_q    <= cfg.data[3:0];
				CFG_KEY_TABLE_ONE:  table_one_q <= cfg.data[KEY_TABLE_W-1:0];
				CFG_KEY_TABLE_TWO:  table_two_q <= cfg.data[KEY_TABLE_W-1:0];
				CFG_PAD_A_PRESENT:  pad_a_q     <= cfg.data[0];
				CFG_PAD_B_PRESENT:  pad_b_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt_in.ready) begin
			v_s1 <= evt_in.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (evt_in.valid && evt_in.ready) begin
			ev_s1 <= evt_in.payload;
		end
	end

	// Channel decoders; each takes key table one or two according to its mode.
	assign tab_a = (mode_a_q == CH_KEYS1) ? table_one_q : table_two_q;
	assign tab_b = (mode_b_q == CH_KEYS1) ? table_one_q : table_two_q;

	jpi_channel u_chan_a (
		.ev      (ev_s1),
		.mode    (mode_a_q),
		.present (pad_a_q),
		.tab     (tab_a),
		.bits_q  (stick_a_q),
		.res     (ch_a)
	);

	jpi_channel u_chan_b (
		.ev      (ev_s1),
		.mode    (mode_b_q),
		.present (pad_b_q),
		.tab     (tab_b),
		.bits_q  (stick_b_q),
		.res     (ch_b)
	);

	assign swallow = ch_a.took || ch_b.took;

	// Mask build for the selected interface style.
	always_comb begin
		mask = MASK_IDLE;
		grab = 1'b0;
		case (kind_q)
			IF_STYLE_ONE: begin
				if ((ev_s1.port_a_select & SEL_STICK_HI) != 8'h00) begin
					mask = apply_bits(mask, ch_a.bits, 1'b0);
					grab = 1'b1;
				end
				if ((ev_s1.port_a_select & SEL_STICK_LO) != 8'h00) begin
					mask = apply_bits(mask, ch_b.bits, 1'b0);
					grab = 1'b1;
				end
			end
			IF_STYLE_TWO: begin
				mask = MASK_TWO_BASE;
				if (ev_s1.ddr_b_bit4 && !ev_s1.port_b_bit4) begin
					grab = 1'b1;
					// Both select bits set leaves the base mask alone.
					if (ev_s1.port_a_select[7:6] != 2'b11) begin
						if (ev_s1.port_a_select[6]) begin
							mask = apply_bits(mask, ch_a.bits, 1'b1);
						end
						if (ev_s1.port_a_select[7]) begin
							mask = apply_bits(mask, ch_b.bits, 1'b1);
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Port A drive and ownership hand-off.
	always_comb begin
		res_d.swallowed        = swallow;
		res_d.port_write       = 1'b0;
		res_d.port_write_value = 8'h00;
		res_d.joystick_mask    = swallow ? mask : last_mask_q;
		owned_d                = owned_q;
		if (swallow) begin
			if (grab) begin
				res_d.port_write       = 1'b1;
				res_d.port_write_value = mask;
				owned_d                = 1'b0;
			end else if (!owned_q) begin
				res_d.port_write       = 1'b1;
				res_d.port_write_value = ev_s1.sound_port_value;
				owned_d                = 1'b1;
			end
		end
	end

	// State update as a consumed item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_a_q   <= '0;
			stick_b_q   <= '0;
			owned_q     <= 1'b1;
			last_mask_q <= MASK_IDLE;
		end else if (advance_s1 && swallow) begin
			stick_a_q   <= ch_a.bits;
			stick_b_q   <= ch_b.bits;
			owned_q     <= owned_d;
			last_mask_q <= mask;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			res_q <= res_d;
		end
	end

	// An event that nobody takes leaves the mask and ownership untouched.
	a_idle_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && !swallow |=> $stable(last_mask_q) && $stable(owned_q))
		else $error("unconsumed event changed the port state");

	// A claimed port drives the new mask and leaves the sound chip without it.
	a_grab_drive: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && swallow && grab |=>
		!owned_q && res_q.port_write && (res_q.port_write_value == last_mask_q))
		else $error("claimed port did not drive the mask");

	// A result that drives the port always comes from a consumed event.
	a_write_needs_swallow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.port_write |-> res_q.swallowed)
		else $error("port write without a consumed event");

	// Without an interface style a consumed event hands the port to the sound chip.
	a_no_style_sound: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && swallow && (kind_q != IF_STYLE_ONE) && (kind_q != IF_STYLE_TWO)
		|=> owned_q)
		else $error("port claimed with no interface style");

endmodule
